FILE: hw/rtl/decision_tree_pixel_classifier_macros.svh
// Assertion macros shared by the decision tree pixel classifier.
`ifndef DECISION_TREE_PIXEL_CLASSIFIER_MACROS_SVH
`define DECISION_TREE_PIXEL_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dtpc_pkg.sv
// Shared types and constants of the decision tree pixel classifier.
package dtpc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NUM_BANDS = 8;
  localparam int MAX_WALK  = 50;

  localparam int IDX_W    = 10;
  localparam int CLASS_W  = 16;
  localparam int BANDF_W  = 3;
  localparam int THR_W    = 17;
  localparam int SAMPLE_W = 16;

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int BAND_AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CNT_W   = $clog2(NUM_BANDS + 1);
  localparam int MOVE_W  = $clog2(MAX_WALK + 1);

  localparam int TDATA_W = 88;

  localparam logic OP_NODE = 1'b0;
  localparam logic OP_BAND = 1'b1;

  localparam logic CFG_NODATA_ENABLE = 1'b0;
  localparam logic CFG_NODATA_VALUE  = 1'b1;

  typedef struct packed {
    logic                      leaf;
    logic [CLASS_W-1:0]        cls;
    logic [BANDF_W-1:0]        band;
    logic signed [THR_W-1:0]   thr;
    logic [IDX_W-1:0]          left;
    logic [IDX_W-1:0]          right;
  } node_t;

  typedef struct packed {
    logic                       nodata_enable;
    logic signed [SAMPLE_W-1:0] nodata_value;
  } walk_cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    logic signed [SAMPLE_W-1:0] band0;
  } band_stat_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_id;
    logic               walk_error;
  } walk_res_t;

endpackage

FILE: hw/rtl/dtpc_node_mem.sv
// Node table: single write port, registered read port.
module dtpc_node_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [dtpc_pkg::NODE_AW-1:0]  waddr,
  input  dtpc_pkg::node_t               wdata,
  input  logic                          re,
  input  logic [dtpc_pkg::NODE_AW-1:0]  raddr,
  output dtpc_pkg::node_t               rdata
);

  dtpc_pkg::node_t mem [dtpc_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/dtpc_band_store.sv
// Band sample registers of the current pixel and their fill count.
module dtpc_band_store (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr,
  input  logic signed [dtpc_pkg::SAMPLE_W-1:0] wr_value,
  input  logic                                 clr,
  input  logic [dtpc_pkg::BAND_AW-1:0]         rd_sel,
  output logic signed [dtpc_pkg::SAMPLE_W-1:0] rd_value,
  output dtpc_pkg::band_stat_t                 stat
);

  logic signed [dtpc_pkg::SAMPLE_W-1:0] bands [dtpc_pkg::NUM_BANDS];
  logic [dtpc_pkg::CNT_W-1:0]           cnt;
  logic                                 has_room;

  assign has_room = (int'(cnt) < dtpc_pkg::NUM_BANDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (clr) begin
      cnt <= '0;
    end else if (wr && has_room) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Samples past the last band still belong to the pixel but are dropped and not counted.
  always_ff @(posedge clk) begin
    if (wr && has_room) begin
      bands[dtpc_pkg::BAND_AW'(cnt)] <= wr_value;
    end
  end

  assign rd_value    = bands[rd_sel];
  assign stat.cnt    = cnt;
  assign stat.band0  = bands[0];

endmodule

FILE: hw/rtl/dtpc_walker.sv
// Tree walk sequencer with one shared threshold compare per node visit.
module dtpc_walker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  dtpc_pkg::walk_cfg_t                  cfg,
  input  dtpc_pkg::band_stat_t                 bstat,
  output logic [dtpc_pkg::BAND_AW-1:0]         band_sel,
  input  logic signed [dtpc_pkg::SAMPLE_W-1:0] band_val,
  output logic                                 mem_re,
  output logic [dtpc_pkg::NODE_AW-1:0]         mem_raddr,
  input  dtpc_pkg::node_t                      node,
  output logic                                 idle,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output dtpc_pkg::walk_res_t                  res
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_DONE  = 4'b1000
  } walk_state_t;

  localparam logic [dtpc_pkg::IDX_W:0] NODE_LIMIT = (dtpc_pkg::IDX_W + 1)'(dtpc_pkg::MAX_NODES);

  walk_state_t                      state, state_next;
  logic [dtpc_pkg::MOVE_W-1:0]      moves, moves_next;
  dtpc_pkg::walk_res_t              result, result_next;
  logic                             go_left;
  logic [dtpc_pkg::IDX_W-1:0]       child;
  logic                             stuck;

  assign band_sel = dtpc_pkg::BAND_AW'(node.band);
  // Threshold carries one fractional bit, so the sample is doubled exactly.
  assign go_left  = ($signed({band_val, 1'b0}) <= node.thr);
  assign child    = go_left ? node.left : node.right;
  assign stuck    = (moves >= dtpc_pkg::MOVE_W'(dtpc_pkg::MAX_WALK)) ||
                    (int'(node.band) >= int'(bstat.cnt)) ||
                    (int'(node.band) >= dtpc_pkg::NUM_BANDS);

  always_comb begin
    state_next  = state;
    moves_next  = moves;
    result_next = result;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cfg.nodata_enable && (bstat.cnt != '0) && (bstat.band0 == cfg.nodata_value)) begin
          result_next = '{class_id: '0, walk_error: 1'b0};
          state_next  = ST_DONE;
        end else begin
          mem_re     = 1'b1;
          moves_next = '0;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (node.leaf) begin
          result_next = '{class_id: node.cls, walk_error: 1'b0};
          state_next  = ST_DONE;
        end else if (stuck || ({1'b0, child} >= NODE_LIMIT)) begin
          result_next = '{class_id: '0, walk_error: 1'b1};
          state_next  = ST_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = dtpc_pkg::NODE_AW'(child);
          moves_next = moves + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    moves  <= moves_next;
    result <= result_next;
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = result;

endmodule

FILE: hw/rtl/decision_tree_pixel_classifier.sv
// A pixel's result follows its last sample: for a no-data pixel the sequencer goes from
// check straight to done; else it reads one node table entry per node visited.
// Node writes and non-final samples are taken back to back while idle; after a final sample
// no request is taken until the result is accepted. The node table read port sets the rate.
// Reset (rst, synchronous, active high) clears the sequencer, band count and no-data regs;
// the node table is not cleared and must be written before it is walked.
module decision_tree_pixel_classifier (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // node_index, node_is_leaf, node_class, node_band, node_threshold, node_left,
  // node_right, band_value, zero padding
  input  logic [dtpc_pkg::TDATA_W-1:0] s_tdata,
  // opcode
  input  logic [0:0]                   s_tuser,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // class_id
  output logic [15:0]                  m_tdata,
  // walk_error
  output logic [0:0]                   m_tuser,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [15:0]                  cfg_wdata
);

  localparam logic [dtpc_pkg::IDX_W:0] NODE_LIMIT = (dtpc_pkg::IDX_W + 1)'(dtpc_pkg::MAX_NODES);

  dtpc_pkg::walk_cfg_t                  cfg;
  dtpc_pkg::node_t                      wr_node;
  dtpc_pkg::node_t                      rd_node;
  dtpc_pkg::band_stat_t                 bstat;
  dtpc_pkg::walk_res_t                  res;
  logic [dtpc_pkg::IDX_W-1:0]           wr_idx;
  logic signed [dtpc_pkg::SAMPLE_W-1:0] sample;
  logic signed [dtpc_pkg::SAMPLE_W-1:0] band_val;
  logic [dtpc_pkg::BAND_AW-1:0]         band_sel;
  logic [dtpc_pkg::NODE_AW-1:0]         mem_raddr;
  logic                                 mem_re;
  logic                                 accept;
  logic                                 node_wr;
  logic                                 band_wr;
  logic                                 start;
  logic                                 idle;
  logic                                 res_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dtpc_pkg::CFG_NODATA_ENABLE: cfg.nodata_enable <= cfg_wdata[0];
        dtpc_pkg::CFG_NODATA_VALUE:  cfg.nodata_value  <= cfg_wdata;
        default: cfg <= cfg;
      endcase
    end
  end

  assign wr_idx        = s_tdata[9:0];
  assign wr_node.leaf  = s_tdata[10];
  assign wr_node.cls   = s_tdata[26:11];
  assign wr_node.band  = s_tdata[29:27];
  assign wr_node.thr   = s_tdata[46:30];
  assign wr_node.left  = s_tdata[56:47];
  assign wr_node.right = s_tdata[66:57];
  assign sample        = s_tdata[82:67];

  assign s_tready = idle;
  assign accept   = s_tvalid && s_tready;
  assign node_wr  = accept && (s_tuser[0] == dtpc_pkg::OP_NODE) && ({1'b0, wr_idx} < NODE_LIMIT);
  assign band_wr  = accept && (s_tuser[0] == dtpc_pkg::OP_BAND);
  assign start    = band_wr && s_tlast;
  assign res_done = m_tvalid && m_tready;

  dtpc_node_mem u_node_mem (
    .clk   (clk),
    .we    (node_wr),
    .waddr (dtpc_pkg::NODE_AW'(wr_idx)),
    .wdata (wr_node),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_node)
  );

  dtpc_band_store u_band_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (band_wr),
    .wr_value (sample),
    .clr      (res_done),
    .rd_sel   (band_sel),
    .rd_value (band_val),
    .stat     (bstat)
  );

  dtpc_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg       (cfg),
    .bstat     (bstat),
    .band_sel  (band_sel),
    .band_val  (band_val),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .node      (rd_node),
    .idle      (idle),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata    = res.class_id;
  assign m_tuser[0] = res.walk_error;

`include "decision_tree_pixel_classifier_macros.svh"

  `DTPC_ASSERT_SAME(a_busy_while_result, m_tvalid, !s_tready, "request taken while a result waits")
  `DTPC_ASSERT_SAME(a_error_class_zero, m_tvalid && m_tuser[0], m_tdata == 16'd0, "error result with nonzero class")
  `DTPC_ASSERT_NEXT(a_last_starts_walk, start, !s_tready && !m_tvalid, "final sample did not start a walk")
  `DTPC_ASSERT_SAME(a_count_bound, 1'b1, int'(bstat.cnt) <= dtpc_pkg::NUM_BANDS, "band count out of range")
  `DTPC_ASSERT_NEXT(a_count_cleared, res_done, bstat.cnt == '0, "band count not cleared after result")

endmodule

FILE: dv/tb_decision_tree_pixel_classifier.sv
// Self-checking testbench for the decision tree pixel classifier: node writes and pixel walks.
`timescale 1ns / 100ps

module tb_decision_tree_pixel_classifier;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int TARGET_REQUESTS = 1800;
  localparam int PHASES          = 5;
  localparam int IDLE_PCT        = 12;
  // The longest walk visits MAX_WALK + 1 nodes, one table read each.
  localparam int SETTLE_CYCLES   = dtpc_pkg::MAX_WALK + 10;
  localparam int STALL_LIMIT     = 4000;
  localparam int MAX_PRINTED     = 50;

  // Request word as carried on s_tdata, highest field first.
  typedef struct packed {
    logic [4:0]                           pad;
    logic signed [dtpc_pkg::SAMPLE_W-1:0] band_value;
    logic [dtpc_pkg::IDX_W-1:0]           right;
    logic [dtpc_pkg::IDX_W-1:0]           left;
    logic signed [dtpc_pkg::THR_W-1:0]    thr;
    logic [dtpc_pkg::BANDF_W-1:0]         band;
    logic [dtpc_pkg::CLASS_W-1:0]         cls;
    logic                                 leaf;
    logic [dtpc_pkg::IDX_W-1:0]           index;
  } request_word_t;

  // Mirror of the tree, the current pixel and the no-data registers, plus the
  // classes still owed by the block.
  class pixel_class_book;
    dtpc_pkg::node_t                      nodes [dtpc_pkg::MAX_NODES];
    logic signed [dtpc_pkg::SAMPLE_W-1:0] bands [dtpc_pkg::NUM_BANDS];
    int unsigned                          nbands;
    logic                                 nodata_on;
    logic signed [dtpc_pkg::SAMPLE_W-1:0] nodata_word;
    dtpc_pkg::walk_res_t                  due_q [$];
    int                                   errors;

    function new();
      nbands      = 0;
      nodata_on   = 1'b0;
      nodata_word = '0;
      errors      = 0;
      foreach (bands[i]) bands[i] = '0;
    endfunction

    function void set_regs(logic on, logic signed [dtpc_pkg::SAMPLE_W-1:0] value);
      nodata_on   = on;
      nodata_word = value;
    endfunction

    function dtpc_pkg::walk_res_t classify();
      dtpc_pkg::walk_res_t res;
      dtpc_pkg::node_t     n;
      int unsigned         at;
      int                  lhs;
      int                  rhs;
      res = '0;
      at  = 0;
      if (nodata_on && nbands > 0 && bands[0] == nodata_word) return res;
      for (int moves = 0; moves <= dtpc_pkg::MAX_WALK; moves++) begin
        if (at >= dtpc_pkg::MAX_NODES) begin
          res.walk_error = 1'b1;
          return res;
        end
        n = nodes[at];
        if (n.leaf) begin
          res.class_id = n.cls;
          return res;
        end
        if (moves >= dtpc_pkg::MAX_WALK || n.band >= nbands || n.band >= dtpc_pkg::NUM_BANDS)
        begin
          res.walk_error = 1'b1;
          return res;
        end
        // The threshold carries one fractional bit, so the sample is doubled.
        lhs = 2 * int'(bands[n.band]);
        rhs = $signed(n.thr);
        at  = (lhs <= rhs) ? n.left : n.right;
      end
      return res;
    endfunction

    function void note_request(logic op, request_word_t w, logic last);
      if (op == dtpc_pkg::OP_NODE) begin
        if (w.index < dtpc_pkg::MAX_NODES)
          nodes[w.index] = dtpc_pkg::node_t'{w.leaf, w.cls, w.band, w.thr, w.left, w.right};
        return;
      end
      if (nbands < dtpc_pkg::NUM_BANDS) begin
        bands[nbands] = w.band_value;
        nbands++;
      end
      if (last) begin
        due_q.insert(due_q.size(), classify());
        nbands = 0;
      end
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [dtpc_pkg::CLASS_W-1:0] cls, logic err);
      dtpc_pkg::walk_res_t want;
      if (due_q.size() == 0) begin
        report($sformatf("class %0d delivered with no pixel pending", cls));
        return;
      end
      want = due_q.pop_front();
      if (cls !== want.class_id)
        report($sformatf("class_id %0d, expected %0d", cls, want.class_id));
      if (err !== want.walk_error)
        report($sformatf("walk_error %0b, expected %0b", err, want.walk_error));
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [dtpc_pkg::TDATA_W-1:0]  s_tdata;
  logic [0:0]                    s_tuser;
  logic                          s_tlast;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [15:0]                   m_tdata;
  logic [0:0]                    m_tuser;
  logic                          cfg_we;
  logic [0:0]                    cfg_index;
  logic [15:0]                   cfg_wdata;

  pixel_class_book     book;
  int                  requests;
  int                  quiet;
  bit                  steady;
  bit                  written [dtpc_pkg::MAX_NODES];
  int unsigned         written_list [$];
  logic signed [15:0]  nd_val_now;

  decision_tree_pixel_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) book.check_result(m_tdata, m_tuser[0]);
      if (s_tvalid && s_tready) book.note_request(s_tuser[0], s_tdata, s_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("FAIL decision_tree_pixel_classifier");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(input logic op, input request_word_t w, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= w;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    requests++;
  endtask

  function automatic request_word_t noise_word();
    request_word_t w;
    logic [95:0]   raw;
    raw   = {$urandom, $urandom, $urandom};
    w     = raw[dtpc_pkg::TDATA_W-1:0];
    w.pad = '0;
    return w;
  endfunction

  task automatic put_node(input int unsigned at, input logic leaf, input logic [15:0] cls,
                          input logic [2:0] band, input logic signed [16:0] thr,
                          input int unsigned lo, input int unsigned hi);
    request_word_t w;
    w       = noise_word();
    w.index = dtpc_pkg::IDX_W'(at);
    w.leaf  = leaf;
    w.cls   = cls;
    w.band  = band;
    w.thr   = thr;
    w.left  = dtpc_pkg::IDX_W'(lo);
    w.right = dtpc_pkg::IDX_W'(hi);
    // The last flag means nothing on a node write, so it is left random.
    send(dtpc_pkg::OP_NODE, w, 1'($urandom_range(1)));
    if (!written[at]) begin
      written[at] = 1'b1;
      written_list.insert(written_list.size(), at);
    end
  endtask

  task automatic put_sample(input logic signed [15:0] v, input logic last);
    request_word_t w;
    w            = noise_word();
    w.band_value = v;
    send(dtpc_pkg::OP_BAND, w, last);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3, 4: return 16'($urandom);
      default: return 16'($signed($urandom_range(128)) - 64);
    endcase
  endfunction

  function automatic logic signed [16:0] pick_threshold();
    case ($urandom_range(9))
      0:       return 17'h10000;
      1:       return 17'h0FFFF;
      2, 3:    return 17'($urandom);
      default: return 17'($signed($urandom_range(260)) - 130);
    endcase
  endfunction

  // Children come only from nodes already written, so no walk can reach an
  // unwritten entry. Recent nodes are favored to build deep trees.
  function automatic int unsigned pick_child();
    int unsigned n;
    n = written_list.size();
    if ($urandom_range(3) != 0)
      return written_list[n - 1 - $urandom_range((n > 4) ? 3 : n - 1)];
    return written_list[$urandom_range(n - 1)];
  endfunction

  task automatic put_random_node(input int unsigned at, input int leaf_pct);
    put_node(at, $urandom_range(99) < leaf_pct, 16'($urandom), 3'($urandom), pick_threshold(),
             pick_child(), pick_child());
  endtask

  task automatic build_tree();
    int unsigned k;
    k = $urandom_range(12, 2);
    repeat (k) put_random_node($urandom_range(dtpc_pkg::MAX_NODES - 1, 1), 35);
    put_random_node(0, 5);
  endtask

  task automatic put_pixel();
    int unsigned        count;
    logic signed [15:0] v;
    case ($urandom_range(19))
      0, 1, 2: count = $urandom_range(dtpc_pkg::NUM_BANDS - 1, 1);
      3, 4:    count = $urandom_range(dtpc_pkg::NUM_BANDS + 3, dtpc_pkg::NUM_BANDS + 1);
      default: count = dtpc_pkg::NUM_BANDS;
    endcase
    for (int i = 0; i < count; i++) begin
      v = pick_sample();
      if (i == 0 && $urandom_range(5) == 0) v = nd_val_now;
      put_sample(v, i == count - 1);
      // Occasionally a node is rewritten while the pixel is still arriving.
      if (i + 1 < count && $urandom_range(49) == 0) put_random_node(pick_child(), 50);
    end
  endtask

  task automatic set_regs(input logic on, input logic signed [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= dtpc_pkg::CFG_NODATA_ENABLE;
    cfg_wdata <= {15'($urandom), on};
    @(posedge clk);
    cfg_index <= dtpc_pkg::CFG_NODATA_VALUE;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_regs(on, value);
    nd_val_now = value;
  endtask

  // Holds the sender off until every pending class has arrived, then lets
  // any walk still in flight finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned        pick;
    logic               phase_on;
    logic signed [15:0] phase_val;
    book      = new();
    requests  = 0;
    steady    = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    set_regs(1'b0, 16'sd0);

    // Leaf at the root, extreme fields.
    put_node(dtpc_pkg::MAX_NODES - 1, 1'b1, 16'hFFFF, 3'd7, 17'h10000,
             dtpc_pkg::MAX_NODES - 1, dtpc_pkg::MAX_NODES - 1);
    put_node(0, 1'b1, 16'h1234, 3'd0, 17'h0FFFF, 0, 0);
    put_sample(16'h8000, 1'b1);
    put_node(2, 1'b1, 16'h0000, 3'd0, 17'h00000, 0, 0);
    // Highest band against the highest threshold: 2 * 32767 still goes left.
    put_node(0, 1'b0, 16'h0000, 3'd7, 17'h0FFFF, dtpc_pkg::MAX_NODES - 1, 2);
    for (int i = 0; i < dtpc_pkg::NUM_BANDS; i++)
      put_sample(16'h7FFF, i == dtpc_pkg::NUM_BANDS - 1);
    // A single sample leaves band 7 missing.
    put_sample(16'h0001, 1'b1);
    // Extra samples past the last band, and the lowest value equal to the
    // lowest threshold.
    put_node(0, 1'b0, 16'h0000, 3'd0, 17'h10000, 2, dtpc_pkg::MAX_NODES - 1);
    for (int i = 0; i <= dtpc_pkg::NUM_BANDS; i++) put_sample(16'h8000, i == dtpc_pkg::NUM_BANDS);
    // A root that points back at itself runs into the step bound.
    put_node(0, 1'b0, 16'h0000, 3'd0, 17'h00000, 0, 0);
    put_sample(16'h0005, 1'b1);
    settle();
    set_regs(1'b1, 16'h8000);
    put_sample(16'h8000, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       begin phase_on = 1'b1; phase_val = 16'sd0;  end
        1:       begin phase_on = 1'b0; phase_val = 16'($urandom); end
        2:       begin phase_on = 1'b1; phase_val = 16'h7FFF; end
        3:       begin phase_on = 1'b1; phase_val = 16'h8000; end
        default: begin phase_on = 1'b1; phase_val = 16'($signed($urandom_range(40)) - 20); end
      endcase
      set_regs(phase_on, phase_val);
      steady = (p == 2);
      build_tree();
      while (requests < TARGET_REQUESTS * (p + 1) / PHASES) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          build_tree();
        end else if (pick < 15) begin
          put_random_node(pick_child(), 40);
        end else if (pick < 17) begin
          pick = pick_child();
          put_node(pick, 1'b0, 16'($urandom), 3'($urandom), pick_threshold(), pick, pick);
        end else if (pick < 18) begin
          settle();
        end else begin
          put_pixel();
        end
      end
    end
    steady = 1'b0;

    settle();
    if (book.errors == 0 && book.due_q.size() == 0) begin
      $display("PASS decision_tree_pixel_classifier");
    end else begin
      $display("FAIL decision_tree_pixel_classifier");
    end
    $finish;
  end

endmodule

FILE: decision_tree_pixel_classifier.f
+incdir+hw/rtl
hw/rtl/dtpc_pkg.sv
hw/rtl/dtpc_node_mem.sv
hw/rtl/dtpc_band_store.sv
hw/rtl/dtpc_walker.sv
hw/rtl/decision_tree_pixel_classifier.sv
dv/tb_decision_tree_pixel_classifier.sv
